>>> sv/temporal_mean_background_macros.svh
// Assertion macros shared by the temporal mean background modules.
`ifndef TEMPORAL_MEAN_BACKGROUND_MACROS_SVH
`define TEMPORAL_MEAN_BACKGROUND_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TMB_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("temporal_mean_background: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TMB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("temporal_mean_background: next-cycle check failed");

`endif

>>> sv/tmb_pkg.sv
// Package with sizes, types, codes and helpers of the temporal mean background block.
`timescale 1ns / 1ps
package tmb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_FRAMES = 256;

	localparam int NCH    = 3;
	localparam int PIX_W  = 8;
	localparam int CFG_W  = 9;
	localparam int IDX_W  = 2;
	localparam int SUM_W  = $clog2(MAX_FRAMES * 255 + 1);
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int FPOS_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(SUM_W + 1);

	localparam logic [IDX_W-1:0] REG_FRAME_COUNT  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [CFG_W-1:0]      divisor;
		sum_t [NCH-1:0]        dividend;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		pix_t [NCH-1:0]        quotient;
	} div_rsp_t;

	// Saturate a register value to 1..hi.
	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > hi) begin
			r = CFG_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/tmb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tmb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/tmb_div.sv
// Bit-serial restoring divider, one lane per channel, sharing a step counter.
`timescale 1ns / 1ps
module tmb_div
	import tmb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	`include "temporal_mean_background_macros.svh"

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [CFG_W-1:0] divisor_q;
	logic [CFG_W-1:0] rem_q [NCH];
	sum_t             quo_q [NCH];
	logic [CFG_W-1:0] rem_nxt [NCH];
	sum_t             quo_nxt [NCH];

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			logic [CFG_W:0] t;
			logic [CFG_W:0] diff;
			logic           ge;
			t = {rem_q[i], quo_q[i][SUM_W-1]};
			diff = t - {1'b0, divisor_q};
			ge = (t >= {1'b0, divisor_q});
			rem_nxt[i] = ge ? diff[CFG_W-1:0] : t[CFG_W-1:0];
			quo_nxt[i] = {quo_q[i][SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(SUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			for (int i = 0; i < NCH; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= req.dividend[i];
			end
		end else if (cnt_q != '0) begin
			for (int i = 0; i < NCH; i++) begin
				rem_q[i] <= rem_nxt[i];
				quo_q[i] <= quo_nxt[i];
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		for (int i = 0; i < NCH; i++) begin
			rsp.quotient[i] = quo_q[i][PIX_W-1:0];
		end
	end

	`TMB_ASSERT_NEXT(a_start_loads, req.start, !done_q && cnt_q == CNT_W'(SUM_W))
	`TMB_ASSERT_IMPLIES(a_done_idle, done_q, cnt_q == '0)
	`TMB_ASSERT_NEXT(a_done_holds, done_q && !req.start, done_q)

endmodule

>>> sv/temporal_mean_background.sv
// Top level of the temporal mean background estimator: registers, raster control, sum store.
//
// Channel   Direction  Handshake               Contents
// s_axis    in         s_axis_tvalid/tready    tdata: chan_zero, chan_one, chan_two
// m_axis    out        m_axis_tvalid/tready    tdata: mean_zero, mean_one, mean_two; tlast
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data (frame_count/width/height)
//
// A pixel of a non-final frame takes one sum-memory read, then the write-back.
// A pixel of the last frame then goes on to the bit-serial divider, which produces
// the three means.
// Reset clears positions and registers only; the sum memory is not cleared, since the
// first frame of each background overwrites it.
// A finished mean waits in the output register while the next pixel is taken; a pixel whose
// mean is ready holds in the divider until the output register is free.
`timescale 1ns / 1ps
module temporal_mean_background
	import tmb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [NCH*PIX_W-1:0] s_axis_tdata,   // chan_zero, chan_one, chan_two
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [NCH*PIX_W-1:0] m_axis_tdata,   // mean_zero, mean_one, mean_two
	output logic                 m_axis_tlast,   // last_pixel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	`include "temporal_mean_background_macros.svh"

	state_t state_q, state_nxt;

	logic [CFG_W-1:0]  frame_count_q, frame_width_q, frame_height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [FPOS_W-1:0] fpos_q;

	logic              in_xfer, cfg_xfer, cfg_hit;
	logic              col_wrap, row_wrap, frame_wrap;
	logic [ADDR_W-1:0] addr;

	logic [ADDR_W-1:0]  addr_q;
	pix_t [NCH-1:0]     pix_q;
	logic               first_q, emit_q, final_q;

	logic               mem_re, mem_we;
	sum_t [NCH-1:0]     mem_rdata, mem_wdata;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     out_load;

	pix_t [NCH-1:0] out_data_q;
	logic           out_last_q, out_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign cfg_hit   = cfg_xfer && (cfg_index inside {REG_FRAME_COUNT, REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= clamp_cfg(CFG_W'(1), MAX_FRAMES);
			frame_width_q  <= clamp_cfg(CFG_W'(256), MAX_WIDTH);
			frame_height_q <= clamp_cfg(CFG_W'(256), MAX_HEIGHT);
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_FRAME_COUNT:  frame_count_q  <= clamp_cfg(cfg_data, MAX_FRAMES);
				REG_FRAME_WIDTH:  frame_width_q  <= clamp_cfg(cfg_data, MAX_WIDTH);
				REG_FRAME_HEIGHT: frame_height_q <= clamp_cfg(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	assign col_wrap   = (32'(col_q) + 1) >= 32'(frame_width_q);
	assign row_wrap   = (32'(row_q) + 1) >= 32'(frame_height_q);
	assign frame_wrap = (32'(fpos_q) + 1) >= 32'(frame_count_q);
	assign addr       = ADDR_W'(32'(row_q) * MAX_WIDTH + 32'(col_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fpos_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			fpos_q <= '0;
		end else if (in_xfer) begin
			if (!col_wrap) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				if (!row_wrap) begin
					row_q <= row_q + ROW_W'(1);
				end else begin
					row_q  <= '0;
					fpos_q <= frame_wrap ? '0 : fpos_q + FPOS_W'(1);
				end
			end
		end
	end

	// Pixel context held while its sum is read and written back.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			addr_q  <= addr;
			pix_q   <= s_axis_tdata;
			first_q <= (fpos_q == '0);
			emit_q  <= frame_wrap;
			final_q <= col_wrap && row_wrap;
		end
	end

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			mem_wdata[i] = first_q ? SUM_W'(pix_q[i]) : mem_rdata[i] + SUM_W'(pix_q[i]);
		end
	end

	tmb_ram #(
		.WIDTH(NCH * SUM_W),
		.DEPTH(DEPTH)
	) u_sums (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_q),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr),
		.rdata(mem_rdata)
	);

	always_comb begin
		div_req.start    = (state_q == ST_RD) && emit_q;
		div_req.divisor  = frame_count_q;
		div_req.dividend = mem_wdata;
	end

	tmb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				state_nxt = emit_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mem_re        = 1'b0;
		mem_we        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_re        = s_axis_tvalid;
			end
			ST_RD: begin
				mem_we = 1'b1;
			end
			ST_DIV: begin
				out_load = div_rsp.done && (!out_valid_q || m_axis_tready);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= div_rsp.quotient;
			out_last_q <= final_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`TMB_ASSERT_NEXT(a_accept_then_read, in_xfer, state_q == ST_RD)
	`TMB_ASSERT_IMPLIES(a_load_needs_quotient, out_load, div_rsp.done)
	`TMB_ASSERT_NEXT(a_load_shows_result, out_load, m_axis_tvalid)

endmodule

>>> dv/temporal_mean_background_tb.sv
// Self-checking testbench for the temporal mean background estimator.
`timescale 1ns / 1ps
module temporal_mean_background_tb;
	import tmb_pkg::*;

	localparam int LIMIT        = 1_000_000;
	localparam int SETTLE       = 40;
	localparam int RANDOM_ITEMS = 100;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		pix_t [NCH-1:0] mean;
		logic           last;
	} mean_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [NCH*PIX_W-1:0] s_axis_tdata = '0;    // chan_zero, chan_one, chan_two
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [NCH*PIX_W-1:0] m_axis_tdata;         // mean_zero, mean_one, mean_two
	logic                 m_axis_tlast;         // last_pixel
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Predictor state: register copies, raster position and per-pixel sums.
	sum_t        chan_sum [NCH][DEPTH];
	int unsigned frames_cfg = 1;
	int unsigned width_cfg = MAX_WIDTH;
	int unsigned height_cfg = MAX_HEIGHT;
	int unsigned cur_col = 0;
	int unsigned cur_row = 0;
	int unsigned cur_frame = 0;

	mean_t       mean_q [$];
	string       mean_names [NCH] = '{"mean_zero", "mean_one", "mean_two"};
	int          errors = 0;
	int unsigned cycle_cnt = 0;
	bit          gaps_on = 1'b1;
	int          stall_left = 0;

	temporal_mean_background dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned limit_reg(logic [CFG_W-1:0] v, int unsigned hi);
		if (v == '0)
			return 1;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_FRAME_COUNT:  frames_cfg = limit_reg(data, MAX_FRAMES);
			REG_FRAME_WIDTH:  width_cfg  = limit_reg(data, MAX_WIDTH);
			REG_FRAME_HEIGHT: height_cfg = limit_reg(data, MAX_HEIGHT);
			default:          return;
		endcase
		// Any valid write starts a new background with the next pixel.
		cur_col   = 0;
		cur_row   = 0;
		cur_frame = 0;
	endfunction

	function automatic void accumulate_pixel(pix_t [NCH-1:0] pix);
		int unsigned addr;
		mean_t       m;
		bit          final_px;
		addr = cur_row * MAX_WIDTH + cur_col;
		for (int c = 0; c < NCH; c++) begin
			if (cur_frame == 0)
				chan_sum[c][addr] = sum_t'(pix[c]);
			else
				chan_sum[c][addr] = chan_sum[c][addr] + sum_t'(pix[c]);
		end
		final_px = (cur_col + 1 >= width_cfg) && (cur_row + 1 >= height_cfg);
		if (cur_frame + 1 >= frames_cfg) begin
			for (int c = 0; c < NCH; c++)
				m.mean[c] = pix_t'(chan_sum[c][addr] / frames_cfg);
			m.last = final_px;
			mean_q = {mean_q, m};
		end
		cur_col++;
		if (cur_col >= width_cfg) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= height_cfg) begin
				cur_row = 0;
				cur_frame++;
				if (cur_frame >= frames_cfg)
					cur_frame = 0;
			end
		end
	endfunction

	// Compare every output transfer against the oldest expected mean.
	always @(posedge clk) begin
		mean_t want;
		pix_t  got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (mean_q.size() == 0) begin
				$error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = mean_q.pop_front();
				for (int c = 0; c < NCH; c++) begin
					got = m_axis_tdata[c*PIX_W +: PIX_W];
					if (got !== want.mean[c]) begin
						$error("%s: expected %0d, actual %0d", mean_names[c], want.mean[c], got);
						errors++;
					end
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_pixel: expected %0d, actual %0d", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Output backpressure: always ready with gaps off, else mostly ready with short and occasional long stalls.
	always @(negedge clk) begin
		logic rdy;
		int   r;
		if (!gaps_on) begin
			rdy = 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			rdy = 1'b0;
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				rdy = 1'b1;
			end else begin
				rdy = 1'b0;
				stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
			end
		end
		m_axis_tready <= rdy;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic pix_t [NCH-1:0] random_pixel();
		pix_t [NCH-1:0] pix;
		int             r;
		for (int c = 0; c < NCH; c++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				pix[c] = '0;
			else if (r < 16)
				pix[c] = '1;
			else
				pix[c] = pix_t'($urandom_range(0, 255));
		end
		return pix;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	// with tvalid still high, so back-to-back pixels need not drop tvalid.
	task automatic send_pixel(pix_t [NCH-1:0] pix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = pix;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		accumulate_pixel(pix);
		@(negedge clk);
	endtask

	task automatic wait_results();
		s_axis_tvalid = 1'b0;
		while (mean_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		wait_results();
		// A pixel of a non-final frame leaves no result behind, so let it finish.
		repeat (SETTLE) @(negedge clk);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_geometry(logic [CFG_W-1:0] count, logic [CFG_W-1:0] w,
			logic [CFG_W-1:0] h);
		write_reg(REG_FRAME_COUNT, count);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// With one frame per background each pixel comes back as its own mean.
	task automatic test_passthrough();
		pix_t vals [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		set_geometry(1, 4, 2);
		for (int k = 0; k < 8; k++)
			send_pixel({vals[(k + 2) % 8], vals[(k + 1) % 8], vals[k]});
	endtask

	// Zero in every register acts as one: 1x1 frames, one frame each.
	task automatic test_zero_registers();
		set_geometry(0, 0, 0);
		send_pixel({8'h12, 8'h34, 8'h56});
		send_pixel({8'hFF, 8'h00, 8'hFF});
	endtask

	// A write to the unused index must neither change geometry nor restart the raster.
	task automatic test_unused_index();
		set_geometry(2, 1, 2);
		send_pixel({8'h10, 8'h20, 8'h30});
		write_reg(REG_UNUSED, '1);
		send_pixel({8'hF0, 8'hE0, 8'hD0});
		send_pixel({8'h11, 8'h21, 8'h31});
		send_pixel({8'h0F, 8'h1F, 8'h2F});
	endtask

	// Small sums with truncation, then the largest three-frame sums.
	task automatic test_truncation();
		set_geometry(3, 1, 1);
		send_pixel({8'h01, 8'h02, 8'h01});
		send_pixel({8'h01, 8'h02, 8'h01});
		send_pixel({8'h00, 8'h01, 8'h00});
		send_pixel({8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'hFF, 8'h00, 8'hFE});
	endtask

	// Largest frame count with full-scale and zero channels, then the widest and tallest frames.
	task automatic test_register_extremes();
		gaps_on = 1'b0;
		set_geometry(9'h1FF, 1, 1);
		repeat (256) send_pixel({8'h00, 8'hFF, 8'hFF});
		gaps_on = 1'b1;
		set_geometry(1, 9'h1FF, 1);
		repeat (256) send_pixel(random_pixel());
		set_geometry(1, 1, 9'd300);
		repeat (256) send_pixel(random_pixel());
	endtask

	// Random geometries with whole backgrounds, some cut short, and random pauses.
	task automatic test_random_backgrounds();
		int sent;
		int bg_len;
		int n;
		int pause_at;
		int r;
		bit first_phase;
		logic [CFG_W-1:0] count, w, h;
		sent = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				count = CFG_W'($urandom_range(9, 64));
				w     = CFG_W'($urandom_range(1, 2));
				h     = CFG_W'(1);
			end else begin
				count = CFG_W'($urandom_range(1, 6));
				w     = CFG_W'($urandom_range(1, 8));
				h     = CFG_W'($urandom_range(1, 4));
			end
			if ($urandom_range(0, 9) == 0)
				count = '0;
			if ($urandom_range(0, 9) == 0)
				w = '0;
			set_geometry(count, w, h);
			bg_len = frames_cfg * width_cfg * height_cfg;
			n = bg_len * $urandom_range(1, 2);
			if (bg_len > 1 && $urandom_range(0, 3) == 0)
				n += $urandom_range(1, bg_len - 1);
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			pause_at = (first_phase || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < n; i++) begin
				// Hold the stream until every pending mean has been delivered.
				if (i == pause_at)
					wait_results();
				send_pixel(random_pixel());
				sent++;
			end
			first_phase = 1'b0;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_passthrough();
		test_zero_registers();
		test_unused_index();
		test_truncation();
		test_register_extremes();
		test_random_backgrounds();
		wait_results();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
